// File: hw/rtl/wsst_pkg.sv
// ----------------------------------------------------------------------------
// wsst_pkg: shared types for the weighted select sum tree
// Item, result and command formats, opcodes and queue depths.
// ----------------------------------------------------------------------------
package wsst_pkg;

  localparam int IDX_W    = 6;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 38;

  // depth of the command queue between front and back, and of the result queue
  localparam int CMD_DEPTH = 2;
  localparam int CQ_AW     = $clog2(CMD_DEPTH);
  localparam int RES_DEPTH = 2;
  localparam int RQ_AW     = $clog2(RES_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_RECOMPUTE = 2'd1,
    OP_FIND      = 2'd2,
    OP_NOP       = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_RECOMPUTE = 2'd1,
    CMD_FIND      = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [IDX_W-1:0]    leaf_index;
    logic [WEIGHT_W-1:0] leaf_weight;
    logic [SUM_W-1:0]    search_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_index;
    logic [SUM_W-1:0] total_weight;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [IDX_W-1:0]    leaf_index;
    logic [WEIGHT_W-1:0] leaf_weight;
    logic [SUM_W-1:0]    search_value;
  } cmd_t;

  // back engine status seen by the front
  typedef struct packed {
    logic clearing;
    logic take;
  } back_stat_t;

endpackage

// File: hw/rtl/wsst_front.sv
// ----------------------------------------------------------------------------
// wsst_front: input classifier and command queue
// Decodes each item into a command and holds it until the back takes it.
// ----------------------------------------------------------------------------
module wsst_front #(
  parameter int LEAF_COUNT  = 64,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  wsst_pkg::in_item_t   in_item,
  input  wsst_pkg::back_stat_t stat,
  output logic                 cmd_valid,
  output wsst_pkg::cmd_t       cmd
);

  localparam int             MASK_W   = (WEIGHT_BITS < wsst_pkg::WEIGHT_W) ?
                                        WEIGHT_BITS : wsst_pkg::WEIGHT_W;
  localparam logic [32:0]    WMASK_X  = (33'd1 << MASK_W) - 33'd1;
  localparam logic [wsst_pkg::WEIGHT_W-1:0] WMASK = WMASK_X[wsst_pkg::WEIGHT_W-1:0];
  localparam logic [12:0]    LEAF_LIM = 13'(LEAF_COUNT);

  wsst_pkg::cmd_t               q_r [wsst_pkg::CMD_DEPTH];
  logic [wsst_pkg::CQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [wsst_pkg::CQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [wsst_pkg::CQ_AW:0]     cnt_r, cnt_nxt;
  logic                         accept;
  logic                         pop_cmd;
  wsst_pkg::cmd_t               entry;

  // classify: out-of-range writes become no-ops
  always_comb begin
    entry.leaf_index   = in_item.leaf_index;
    entry.leaf_weight  = in_item.leaf_weight & WMASK;
    entry.search_value = in_item.search_value;
    case (in_item.opcode)
      wsst_pkg::OP_WRITE: begin
        entry.kind = ({7'b0, in_item.leaf_index} < LEAF_LIM) ?
                     wsst_pkg::CMD_WRITE : wsst_pkg::CMD_NOP;
      end
      wsst_pkg::OP_RECOMPUTE: begin
        entry.kind = wsst_pkg::CMD_RECOMPUTE;
      end
      wsst_pkg::OP_FIND: begin
        entry.kind = wsst_pkg::CMD_FIND;
      end
      default: begin
        entry.kind = wsst_pkg::CMD_NOP;
      end
    endcase
  end

  assign full      = (cnt_r == (wsst_pkg::CQ_AW+1)'(wsst_pkg::CMD_DEPTH)) || stat.clearing;
  assign accept    = push && !full;
  assign pop_cmd   = stat.take;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (accept) begin
      wr_ptr_nxt = (wr_ptr_r == wsst_pkg::CQ_AW'(wsst_pkg::CMD_DEPTH-1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop_cmd) begin
      rd_ptr_nxt = (rd_ptr_r == wsst_pkg::CQ_AW'(wsst_pkg::CMD_DEPTH-1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + (wsst_pkg::CQ_AW+1)'(accept) - (wsst_pkg::CQ_AW+1)'(pop_cmd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// File: hw/rtl/wsst_back.sv
// ----------------------------------------------------------------------------
// wsst_back: sum tree engine
// Holds the node memory; runs the clearing pass, leaf writes, recompute
// sweeps and root-to-leaf finds, one command at a time.
// ----------------------------------------------------------------------------
module wsst_back #(
  parameter int LEAF_COUNT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  wsst_pkg::cmd_t       cmd,
  output wsst_pkg::back_stat_t stat,
  input  logic                 res_full,
  output logic                 res_push,
  output wsst_pkg::out_item_t  res_item
);

  localparam int LVL   = (LEAF_COUNT > 1) ? $clog2(LEAF_COUNT) : 1;
  localparam int P     = 1 << LVL;
  localparam int NODES = 2 * P - 1;
  localparam int AW    = LVL + 1;
  localparam int LW    = (LVL > 1) ? $clog2(LVL) : 1;
  localparam int SW    = wsst_pkg::SUM_W;

  localparam logic [AW-1:0]  LAST_NODE = AW'(NODES - 1);
  localparam logic [AW-1:0]  LEAF_BASE = AW'(P - 1);
  localparam logic [LVL-1:0] RC_START  = LVL'(P - 2);
  localparam logic [LW-1:0]  LAST_LVL  = LW'(LVL - 1);
  localparam logic [LVL:0]   LEAF_LIM  = (LVL+1)'(LEAF_COUNT);
  localparam logic [LVL-1:0] LEAF_TOP  = LVL'(LEAF_COUNT - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RC_RD = 5'b00100,
    S_RC_WR = 5'b01000,
    S_FIND  = 5'b10000
  } state_t;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SW] ? {SW{1'b1}} : s[SW-1:0];
  endfunction

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [LVL-1:0]  p_r, p_nxt;
  logic [AW-1:0]   node_r, node_nxt;
  logic [LVL-1:0]  path_r, path_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic [SW-1:0]   value_r, value_nxt;
  logic [SW-1:0]   root_r, root_nxt;

  logic [SW-1:0]   mem [NODES];
  logic            we;
  logic [AW-1:0]   wa;
  logic [SW-1:0]   wd;
  logic [AW-1:0]   ra_a, ra_b;
  logic [SW-1:0]   rda_r, rdb_r;

  logic            take;
  logic [SW-1:0]   rc_sum;
  logic            go_right;
  logic [AW-1:0]   node_step;
  logic [LVL-1:0]  path_step;
  logic [LVL-1:0]  leaf_sel;
  logic [SW-1:0]   value_step;

  assign take          = (state_r == S_IDLE) && cmd_valid && !res_full;
  assign stat.take     = take;
  assign stat.clearing = (state_r == S_CLEAR);

  // rda_r holds the left child sum of node_r during a find
  assign rc_sum     = sat_add(rda_r, rdb_r);
  assign go_right   = (value_r > rda_r);
  assign node_step  = AW'({node_r, 1'b1}) + AW'(go_right);
  assign path_step  = LVL'({path_r, go_right});
  assign leaf_sel   = ({1'b0, path_step} >= LEAF_LIM) ? LEAF_TOP : path_step;
  assign value_step = go_right ? (value_r - rda_r) : value_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    p_nxt     = p_r;
    node_nxt  = node_r;
    path_nxt  = path_r;
    lvl_nxt   = lvl_r;
    value_nxt = value_r;
    root_nxt  = root_r;
    we        = 1'b0;
    wa        = clr_r;
    wd        = '0;
    ra_a      = {p_r, 1'b1};
    ra_b      = {p_r, 1'b0} + AW'(2);
    res_push  = 1'b0;
    res_item.chosen_index = '0;
    res_item.total_weight = root_r;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        if (clr_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (take) begin
          case (cmd.kind)
            wsst_pkg::CMD_WRITE: begin
              we       = 1'b1;
              wa       = LEAF_BASE + AW'(cmd.leaf_index);
              wd       = SW'(cmd.leaf_weight);
              res_push = 1'b1;
            end
            wsst_pkg::CMD_RECOMPUTE: begin
              p_nxt     = RC_START;
              state_nxt = S_RC_RD;
            end
            wsst_pkg::CMD_FIND: begin
              ra_a      = AW'(1);
              node_nxt  = '0;
              path_nxt  = '0;
              lvl_nxt   = '0;
              value_nxt = cmd.search_value;
              state_nxt = S_FIND;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_RC_RD: begin
        state_nxt = S_RC_WR;
      end
      S_RC_WR: begin
        we = 1'b1;
        wa = AW'(p_r);
        wd = rc_sum;
        if (p_r == '0) begin
          root_nxt              = rc_sum;
          res_push              = 1'b1;
          res_item.total_weight = rc_sum;
          state_nxt             = S_IDLE;
        end else begin
          p_nxt     = p_r - 1'b1;
          state_nxt = S_RC_RD;
        end
      end
      S_FIND: begin
        node_nxt  = node_step;
        path_nxt  = path_step;
        value_nxt = value_step;
        ra_a      = AW'({node_step, 1'b1});
        if (lvl_r == LAST_LVL) begin
          res_push              = 1'b1;
          res_item.chosen_index = wsst_pkg::IDX_W'(leaf_sel);
          state_nxt             = S_IDLE;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      root_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      root_r  <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    node_r  <= node_nxt;
    path_r  <= path_nxt;
    lvl_r   <= lvl_nxt;
    value_r <= value_nxt;
  end

  // node memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_r <= mem[ra_a];
    rdb_r <= mem[ra_b];
  end

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result transfer into a full result queue");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (wa <= LAST_NODE))
    else $error("node write beyond the tree");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (!take && !res_push))
    else $error("activity during the clearing pass");

  a_root_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RC_WR && p_r == '0) |=> (root_r == $past(rc_sum)))
    else $error("root total out of step with node zero");
`endif

endmodule

// File: hw/rtl/wsst_res_q.sv
// ----------------------------------------------------------------------------
// wsst_res_q: result queue
// Short queue between the engine and the result port.
// ----------------------------------------------------------------------------
module wsst_res_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  wsst_pkg::out_item_t res_item,
  output logic                res_full,
  output logic                empty,
  input  logic                pop,
  output wsst_pkg::out_item_t out_item
);

  wsst_pkg::out_item_t        q_r [wsst_pkg::RES_DEPTH];
  logic [wsst_pkg::RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [wsst_pkg::RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [wsst_pkg::RQ_AW:0]   cnt_r, cnt_nxt;
  logic                       wr;
  logic                       rd;

  assign res_full = (cnt_r == (wsst_pkg::RQ_AW+1)'(wsst_pkg::RES_DEPTH));
  assign empty    = (cnt_r == '0);
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;
  assign out_item = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == wsst_pkg::RQ_AW'(wsst_pkg::RES_DEPTH-1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == wsst_pkg::RQ_AW'(wsst_pkg::RES_DEPTH-1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + (wsst_pkg::RQ_AW+1)'(wr) - (wsst_pkg::RQ_AW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_ptr_r] <= res_item;
    end
  end

endmodule

// File: hw/rtl/weighted_select_sum_tree_top.sv
// ----------------------------------------------------------------------------
// weighted_select_sum_tree_top: sum tree for weighted random selection
// Leaf weights in a binary tree of sums; write, recompute and find.
// ----------------------------------------------------------------------------
// The tree has P leaves, P being LEAF_COUNT rounded up to a power of two,
// and 2P-1 nodes of 38 bits in a single node memory (one write port, two
// registered read ports). After reset a clearing pass zeroes the memory one
// node per cycle, during which full stays high. Every transfer in gives
// exactly one result, in order. Once the engine holds a command, a leaf
// write or no-op gives its result as it is taken; a find makes one read of
// the node memory per tree level, the compare and subtract of one level
// feeding the next read address; a recompute takes the command and then
// makes one read of both children and one write of the parent per inner
// node. Leaf writes leave the inner sums stale until a recompute; finds and
// the reported total use the sums as they stand. Inner sums saturate at
// 2^38-1, and a find that ends on a padding leaf reports the last real leaf.
// ----------------------------------------------------------------------------
module weighted_select_sum_tree_top #(
  parameter int LEAF_COUNT  = 64,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  output logic                full,
  input  wsst_pkg::in_item_t  in_item,
  // result channel
  output logic                empty,
  input  logic                pop,
  output wsst_pkg::out_item_t out_item
);

  wsst_pkg::back_stat_t stat;
  logic                 cmd_valid;
  wsst_pkg::cmd_t       cmd;
  logic                 res_full;
  logic                 res_push;
  wsst_pkg::out_item_t  res_item;

  // front: decode and buffer commands
  wsst_front #(
    .LEAF_COUNT  (LEAF_COUNT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .stat      (stat),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // back: tree engine; takes a command only with room for its result
  wsst_back #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .stat      (stat),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // result queue towards the consumer
  wsst_res_q u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_item (res_item),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

// File: test/tb_weighted_select_sum_tree_top.sv
// ----------------------------------------------------------------------------
// tb_weighted_select_sum_tree_top: self-checking bench for the sum tree
// Drives leaf writes, recomputes, finds and no-ops through the input queue,
// predicts every result from a private copy of the node sums and checks each
// transfer on the result queue in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_weighted_select_sum_tree_top;
  import wsst_pkg::*;

  localparam int LEAF_COUNT   = 64;
  localparam int WEIGHT_BITS  = 32;
  localparam int PAD_LEAVES   = 1 << $clog2(LEAF_COUNT);
  localparam int LEAF_BASE    = PAD_LEAVES - 1;        // node number of leaf 0
  localparam int NODE_COUNT   = 2 * PAD_LEAVES - 1;
  localparam int ITEM_TARGET  = 1450;
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_OFF     = 400;                   // long output stall, cycles
  localparam int HOLD_AT      = 300;                   // results checked before it
  localparam int PAUSE_AT     = 1000;                  // items sent before the drain
  localparam int QUIET_LIMIT  = 5000;                  // cycles without a transfer
  localparam int DRAIN_CYCLES = 20;

  localparam logic [SUM_W-1:0]    SUM_TOP    = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = '1;

  // --------------------------------------------------------------------------
  // Tree predictor plus the queue of results still owed by the block.
  // --------------------------------------------------------------------------
  class select_tree_checker;
    bit [SUM_W-1:0] node_sum [NODE_COUNT];
    out_item_t      due [$];
    int unsigned    op_seen [4];
    int unsigned    checked;
    int unsigned    mismatches;

    function new();
      foreach (node_sum[n]) node_sum[n] = '0;
      foreach (op_seen[n]) op_seen[n] = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function bit [SUM_W-1:0] sat_add(bit [SUM_W-1:0] a, bit [SUM_W-1:0] b);
      bit [SUM_W:0] s;
      s = a + b;
      return s[SUM_W] ? SUM_TOP : s[SUM_W-1:0];
    endfunction

    function out_item_t apply_command(in_item_t c);
      out_item_t      res;
      int             i;
      bit [SUM_W-1:0] v;
      res = '0;
      case (c.opcode)
        OP_WRITE: begin
          if (c.leaf_index < LEAF_COUNT)
            node_sum[LEAF_BASE + c.leaf_index] = SUM_W'(c.leaf_weight);
        end
        OP_RECOMPUTE: begin
          for (int p = LEAF_BASE - 1; p >= 0; p--)
            node_sum[p] = sat_add(node_sum[2*p+1], node_sum[2*p+2]);
        end
        OP_FIND: begin
          i = 0;
          v = c.search_value;
          while (i < LEAF_BASE) begin
            if (v <= node_sum[2*i+1]) begin
              i = 2*i + 1;
            end else begin
              v = v - node_sum[2*i+1];
              i = 2*i + 2;
            end
          end
          i = i - LEAF_BASE;
          if (i >= LEAF_COUNT) i = LEAF_COUNT - 1;   // padding leaf
          res.chosen_index = IDX_W'(i);
        end
        default: ;
      endcase
      res.total_weight = node_sum[0];
      return res;
    endfunction

    function void take_command(in_item_t c);
      op_seen[c.opcode]++;
      due.push_back(apply_command(c));
    endfunction

    function void check_result(out_item_t r);
      out_item_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, chosen %0d total %0d",
                 $time, r.chosen_index, r.total_weight);
        mismatches++;
        return;
      end
      want = due.pop_front();
      checked++;
      if (r.chosen_index !== want.chosen_index) begin
        $display("%0t: chosen_index expected %0d actual %0d",
                 $time, want.chosen_index, r.chosen_index);
        mismatches++;
      end
      if (r.total_weight !== want.total_weight) begin
        $display("%0t: total_weight expected %0d actual %0d",
                 $time, want.total_weight, r.total_weight);
        mismatches++;
      end
    endfunction

    function longint unsigned leaf_prefix(int k);
      longint unsigned s;
      s = 0;
      for (int n = 0; n <= k; n++) s += node_sum[LEAF_BASE + n];
      return s;
    endfunction

    function int outstanding();
      return due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  select_tree_checker tree;
  int unsigned        sent;
  int                 quiet;
  bit                 tx_calm;
  bit                 hold_done;

  weighted_select_sum_tree_top #(
    .LEAF_COUNT (LEAF_COUNT),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Transfers are seen at the rising edge, before the block's own updates land.
  // The same block keeps the watchdog: it counts edges with no transfer either way,
  // which also covers the clearing pass after reset and a full recompute.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) tree.take_command(in_item);
      if (pop && !empty) tree.check_result(out_item);
      if ((push && !full) || (pop && !empty)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles, %0d results owed",
                 $time, quiet, tree.outstanding());
        $display("weighted_select_sum_tree_top test failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Receiver: random pops, a calm stretch, and once a long hold-off so that both
  // queues fill and full rises while the sender keeps offering.
  initial begin
    int hold_left;
    bit rx_calm;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      rx_calm = (tree.checked >= 700) && (tree.checked < 900);
      if (!hold_done && tree.checked >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // push is assigned once per edge, so a held push never dips between items.
  task automatic send_item(input in_item_t c);
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (full);
    sent++;
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(opcode_t op, bit [IDX_W-1:0] idx,
                                         bit [WEIGHT_W-1:0] w, bit [SUM_W-1:0] v);
    in_item_t c;
    c.opcode       = op;
    c.leaf_index   = idx;
    c.leaf_weight  = w;
    c.search_value = v;
    return c;
  endfunction

  function automatic bit [SUM_W-1:0] rand_sum();
    bit [63:0] r;
    r = {$urandom, $urandom};
    return r[SUM_W-1:0];
  endfunction

  function automatic bit [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return WEIGHT_TOP;
      2, 3:    return $urandom_range(1, 255);
      default: return $urandom;
    endcase
  endfunction

  // Search values mostly inside the current total, with exact leaf boundaries
  // (the walk goes left on equality) and now and then far beyond the total.
  function automatic bit [SUM_W-1:0] pick_value();
    bit [63:0]      r;
    bit [SUM_W-1:0] top;
    int             k;
    top = tree.node_sum[0];
    r   = {$urandom, $urandom};
    k   = $urandom_range(LEAF_COUNT - 1);
    case ($urandom_range(7))
      0:       return top;
      1:       return SUM_W'(tree.leaf_prefix(k));
      2:       return SUM_W'(tree.leaf_prefix(k) + 1);
      3:       return rand_sum();
      default: return SUM_W'(r % (top + 1));
    endcase
  endfunction

  task automatic run_directed();
    // empty tree: a find of zero ends on leaf 0, one of the top value on the last leaf
    send_item(make_item(OP_FIND, '0, '0, '0));
    send_item(make_item(OP_FIND, '1, WEIGHT_TOP, SUM_TOP));
    // no-op with every field at its top, then at zero
    send_item(make_item(OP_NOP, '1, WEIGHT_TOP, SUM_TOP));
    send_item(make_item(OP_NOP, '0, '0, '0));
    // outer leaves at full weight; sums stay stale until the recompute
    send_item(make_item(OP_WRITE, '0, WEIGHT_TOP, '0));
    send_item(make_item(OP_WRITE, IDX_W'(LEAF_COUNT - 1), WEIGHT_TOP, SUM_TOP));
    send_item(make_item(OP_FIND, '0, '0, 38'd5));
    send_item(make_item(OP_RECOMPUTE, '1, '0, '0));
    send_item(make_item(OP_FIND, '0, '0, '0));
    send_item(make_item(OP_FIND, '0, '0, {6'd0, WEIGHT_TOP}));
    send_item(make_item(OP_FIND, '0, '0, 38'h1_0000_0000));
    send_item(make_item(OP_FIND, '0, '0, SUM_TOP));        // beyond the total
    // a weight of one in the middle, checked at its boundaries
    send_item(make_item(OP_WRITE, 6'd37, 32'd1, '0));
    send_item(make_item(OP_WRITE, 6'd38, '0, '0));
    send_item(make_item(OP_RECOMPUTE, '0, '0, '0));
    send_item(make_item(OP_FIND, '0, '0, {6'd0, WEIGHT_TOP}));
    send_item(make_item(OP_FIND, '0, '0, 38'h1_0000_0001));
    send_item(make_item(OP_FIND, '0, '0, 38'h1_0000_0002));
    // zero leaf 0 and walk with zero: left all the way down
    send_item(make_item(OP_WRITE, '0, '0, '0));
    send_item(make_item(OP_RECOMPUTE, '0, '0, '0));
    send_item(make_item(OP_FIND, '0, '0, '0));
    send_item(make_item(OP_FIND, '0, '0, 38'd1));
  endtask

  // Well-formed use: a run of leaf writes, a recompute, then finds on fresh sums.
  task automatic run_build_and_pick(input bit heavy);
    int n_w;
    int n_f;
    n_w = heavy ? $urandom_range(16, 40) : $urandom_range(1, 6);
    n_f = $urandom_range(2, 8);
    repeat (n_w)
      send_item(make_item(OP_WRITE, IDX_W'($urandom_range(LEAF_COUNT - 1)),
                          heavy ? WEIGHT_TOP - $urandom_range(255) : rand_weight(),
                          rand_sum()));
    send_item(make_item(OP_RECOMPUTE, IDX_W'($urandom_range(63)), $urandom, rand_sum()));
    repeat (n_f)
      send_item(make_item(OP_FIND, IDX_W'($urandom_range(63)), $urandom, pick_value()));
  endtask

  // Noise: any opcode, stale finds included, fields random, search values random or picked.
  task automatic run_noise();
    repeat ($urandom_range(1, 4))
      send_item(make_item(opcode_t'($urandom_range(3)), IDX_W'($urandom_range(63)),
                          rand_weight(), $urandom_range(1) ? rand_sum() : pick_value()));
  endtask

  initial begin
    int  roll;
    bit  paused;
    tree      = new();
    rst_n     = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    sent      = 0;
    tx_calm   = 1'b0;
    paused    = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    while (sent < ITEM_TARGET) begin
      tx_calm = (sent >= 700) && (sent < 900);
      if (!paused && sent >= PAUSE_AT) begin
        // sender stands back until every owed result has been popped
        paused = 1'b1;
        push <= 1'b0;
        @(negedge clk);
        while (tree.outstanding() != 0) @(negedge clk);
      end
      roll = $urandom_range(99);
      if (roll < 60)      run_build_and_pick(1'b0);
      else if (roll < 66) run_build_and_pick(1'b1);
      else                run_noise();
    end
    push <= 1'b0;

    while (tree.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items: %0d leaf writes, %0d recomputes, %0d finds, %0d no-ops.",
             sent, tree.op_seen[OP_WRITE], tree.op_seen[OP_RECOMPUTE],
             tree.op_seen[OP_FIND], tree.op_seen[OP_NOP]);
    $display("Checked %0d results through a %0d-cycle output stall and a mid-run drain.",
             tree.checked, HOLD_OFF);
    if (tree.mismatches == 0 && tree.outstanding() == 0) begin
      $display("weighted_select_sum_tree_top test passed");
    end else begin
      $display("weighted_select_sum_tree_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wsst_pkg.sv
hw/rtl/wsst_front.sv
hw/rtl/wsst_back.sv
hw/rtl/wsst_res_q.sv
hw/rtl/weighted_select_sum_tree_top.sv
test/tb_weighted_select_sum_tree_top.sv
